[sv/pfra_pkg.sv]
package pfra_pkg;

  localparam int COORD_FRAC_BITS = 10;
  // extra quotient bits of the force division: 2^(3F-16)
  localparam int MAG_SHIFT       = 3 * COORD_FRAC_BITS - 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  // m * q2 is below 2^57
  localparam int MQ_W       = 57;
  localparam int SQRT_STEPS = 15;
  localparam int Q_STEPS    = 32;
  localparam int MAG_STEPS  = MQ_W + MAG_SHIFT;
  localparam int DIV_W      = MAG_STEPS;
  localparam int DEN_W      = 45;
  localparam int REM_W      = DEN_W + 1;
  localparam int QUO_W      = 48;
  localparam int CNT_W      = $clog2(MAG_STEPS);

  localparam logic [31:0] DEN_SCALE = 32'd25600;

  typedef enum logic [1:0] {
    CFG_COST_THRESHOLD,
    CFG_INFLUENCE_RADIUS,
    CFG_SAFETY_RADIUS,
    CFG_REPULSIVE_GAIN
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_RR,
    OP_SS,
    OP_GC,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_Q1_INIT,
    OP_DIV_STEP,
    OP_MUL_DEN,
    OP_DEN_SAVE,
    OP_MUL_Q,
    OP_Q2_INIT,
    OP_MUL_M,
    OP_MAG_INIT,
    OP_ACC,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis;
  } pfra_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic slot_free;
  } pfra_sts_t;

endpackage

[sv/potential_field_repulsion_accumulator.sv]
// a cell outside the field skips the root and the divisions; an obstacle cell runs
// the 15-step root, the 32-step q1 division, then per axis the 32-step q2 division
// and the 71-step force division, all divisions on one shared divider
// throughput: one cell at a time; a result waits in an output register
// reset: synchronous active-low, restores register defaults and clears both sums
module potential_field_repulsion_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pfra_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pfra_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pfra_pkg::IN_DATA_W-1:0]    in_tdata,   // offset_x, offset_y, cell_cost
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfra_pkg::OUT_DATA_W-1:0]   out_tdata   // force_x, force_y
);
  import pfra_pkg::*;

  pfra_cmd_t cmd;
  pfra_sts_t sts;

  pfra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pfra_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[sv/pfra_dp.sv]
module pfra_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pfra_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pfra_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [pfra_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfra_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  pfra_pkg::pfra_cmd_t                 cmd,
  output pfra_pkg::pfra_sts_t                 sts
);
  import pfra_pkg::*;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  // configuration
  logic signed [7:0] thr_r;
  logic [14:0]       rad_r;
  logic [14:0]       safe_r;
  logic [15:0]       gain_r;

  // request
  logic signed [15:0] ox_r, oy_r;
  logic [15:0]        ax_r, ay_r;
  logic signed [7:0]  cost_r;
  logic               last_r;

  logic [63:0] prod_r;
  logic [31:0] d2_r;
  logic        hit_r, tri_r;
  logic [22:0] gc_r;
  logic [24:0] m_r;

  logic [29:0] sq_val_r;
  logic [16:0] sq_rem_r;
  logic [14:0] root_r;

  logic [REM_W-1:0] rem_r;
  logic [DIV_W-1:0] dvd_r;
  logic [DEN_W-1:0] dsr_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;
  logic [31:0]      q1_r;
  logic [DEN_W-1:0] den_r;

  logic signed [47:0] sum_x_r, sum_y_r;
  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic signed [7:0] cost_cap;
  logic [7:0]        abs_c;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod_nxt;

  always_comb begin
    cost_cap = (cost_r > 8'sd100) ? 8'sd100 : cost_r;
    abs_c    = cost_cap[7] ? 8'(-cost_cap) : cost_cap;
  end

  // shared multiplier, operands chosen by the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX: begin
        mul_a = 32'(ax_r);
        mul_b = 32'(ax_r);
      end
      OP_SQY: begin
        mul_a = 32'(ay_r);
        mul_b = 32'(ay_r);
      end
      OP_RR: begin
        mul_a = 32'(rad_r);
        mul_b = 32'(rad_r);
      end
      OP_SS: begin
        mul_a = 32'(safe_r);
        mul_b = 32'(safe_r);
      end
      OP_GC: begin
        mul_a = 32'(gain_r);
        mul_b = 32'(abs_c);
      end
      OP_MUL_DEN: begin
        mul_a = DEN_SCALE;
        mul_b = d2_r;
      end
      OP_MUL_Q: begin
        mul_a = q1_r;
        mul_b = cmd.axis ? 32'(ay_r) : 32'(ax_r);
      end
      OP_MUL_M: begin
        mul_a = 32'(m_r);
        mul_b = quo_r[31:0];
      end
      default: ;
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  // square root digit step
  logic [18:0] sq_sh;
  logic [16:0] sq_trial;
  logic        sq_ge;
  always_comb begin
    sq_sh    = {sq_rem_r, sq_val_r[29:28]};
    sq_trial = {root_r, 2'b01};
    sq_ge    = sq_sh >= {2'b00, sq_trial};
  end

  // restoring divider step
  logic [REM_W-1:0] dv_trial;
  logic             dv_ge;
  always_comb begin
    dv_trial = {rem_r[REM_W-2:0], dvd_r[DIV_W-1]};
    dv_ge    = dv_trial >= {1'b0, dsr_r};
  end

  // signed term and saturating add
  logic               o_zero, o_pos, t_neg;
  logic [46:0]        mag;
  logic signed [47:0] term, sum_sel;
  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_nxt;
  always_comb begin
    o_zero  = cmd.axis ? (oy_r == 16'sd0) : (ox_r == 16'sd0);
    o_pos   = cmd.axis ? (oy_r > 16'sd0) : (ox_r > 16'sd0);
    t_neg   = cost_r[7] != o_pos;
    mag     = (ovf_r || quo_r[QUO_W-1]) ? 47'h7FFF_FFFF_FFFF : quo_r[46:0];
    if (o_zero || cost_r == 8'sd0) term = '0;
    else if (t_neg)                term = -$signed({1'b0, mag});
    else                           term = $signed({1'b0, mag});
    sum_sel = cmd.axis ? sum_y_r : sum_x_r;
    sum_ext = 49'(sum_sel) + 49'(term);
    if (sum_ext > 49'(ACC_MAX))      sum_nxt = ACC_MAX;
    else if (sum_ext < 49'(ACC_MIN)) sum_nxt = ACC_MIN;
    else                             sum_nxt = sum_ext[47:0];
  end

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v[47:31] == '0 || v[47:31] == '1) r = v[31:0];
    else if (v[47])                       r = 32'h8000_0000;
    else                                  r = 32'h7FFF_FFFF;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= 8'sd50;
      rad_r        <= 15'd2560;
      safe_r       <= 15'd819;
      gain_r       <= 16'd5120;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_COST_THRESHOLD:   thr_r  <= cfg_wdata[7:0];
          CFG_INFLUENCE_RADIUS: rad_r  <= cfg_wdata[14:0];
          CFG_SAFETY_RADIUS:    safe_r <= cfg_wdata[14:0];
          CFG_REPULSIVE_GAIN:   gain_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_EMIT) begin
        out_tvalid_r <= 1'b1;
        sum_x_r      <= '0;
        sum_y_r      <= '0;
      end else begin
        if (out_tready) out_tvalid_r <= 1'b0;
        if (cmd.op == OP_ACC) begin
          if (cmd.axis) sum_y_r <= sum_nxt;
          else          sum_x_r <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      OP_LOAD: begin
        ox_r   <= in_tdata[15:0];
        oy_r   <= in_tdata[31:16];
        cost_r <= in_tdata[39:32];
        ax_r   <= in_tdata[15] ? 16'(-in_tdata[15:0]) : in_tdata[15:0];
        ay_r   <= in_tdata[31] ? 16'(-in_tdata[31:16]) : in_tdata[31:16];
        last_r <= in_tlast;
      end
      OP_SQY: d2_r <= prod_r[31:0];
      OP_RR:  d2_r <= d2_r + prod_r[31:0];
      OP_SS:  hit_r <= (cost_r > thr_r) && (d2_r != '0) && (d2_r < prod_r[31:0]);
      OP_GC:  tri_r <= d2_r < prod_r[31:0];
      OP_SQ_INIT: begin
        gc_r     <= prod_r[22:0];
        sq_val_r <= d2_r[29:0];
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      OP_SQ_STEP: begin
        sq_val_r <= {sq_val_r[27:0], 2'b00};
        if (sq_ge) begin
          sq_rem_r <= 17'(sq_sh - {2'b00, sq_trial});
          root_r   <= {root_r[13:0], 1'b1};
        end else begin
          sq_rem_r <= 17'(sq_sh);
          root_r   <= {root_r[13:0], 1'b0};
        end
      end
      OP_Q1_INIT: begin
        m_r   <= tri_r ? 25'(gc_r) + {1'b0, gc_r, 1'b0} : 25'(gc_r);
        rem_r <= REM_W'(rad_r - root_r);
        dvd_r <= '0;
        dsr_r <= DEN_W'(rad_r);
        quo_r <= '0;
        ovf_r <= 1'b0;
      end
      OP_DIV_STEP: begin
        rem_r <= dv_ge ? dv_trial - {1'b0, dsr_r} : dv_trial;
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], dv_ge};
        ovf_r <= ovf_r | quo_r[QUO_W-1];
      end
      OP_MUL_DEN:  q1_r  <= quo_r[31:0];
      OP_DEN_SAVE: den_r <= prod_r[DEN_W-1:0];
      OP_Q2_INIT: begin
        // high part of q1*|o| is already below d2
        rem_r <= REM_W'(prod_r[46:32]);
        dvd_r <= {prod_r[31:0], (DIV_W-32)'(0)};
        dsr_r <= DEN_W'(d2_r[29:0]);
        quo_r <= '0;
        ovf_r <= 1'b0;
      end
      OP_MAG_INIT: begin
        rem_r <= '0;
        dvd_r <= {prod_r[MQ_W-1:0], MAG_SHIFT'(0)};
        dsr_r <= den_r;
        quo_r <= '0;
        ovf_r <= 1'b0;
      end
      OP_EMIT: out_data_r <= {sat32(sum_y_r), sat32(sum_x_r)};
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign sts        = '{hit: hit_r, last: last_r, slot_free: !out_tvalid_r || out_tready};

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> sum_x_r == '0 && sum_y_r == '0 && out_tvalid_r)
    else $error("accumulators not cleared on emit");

  a_q1_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_MUL_DEN |-> quo_r[QUO_W-1:32] == '0 && !ovf_r)
    else $error("q1 quotient wider than 32 bits");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> !out_tvalid_r || out_tready)
    else $error("emit overwrote a pending result");

endmodule

[sv/pfra_ctrl.sv]
module pfra_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output pfra_pkg::pfra_cmd_t  cmd,
  input  pfra_pkg::pfra_sts_t  sts
);
  import pfra_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_RR, S_SS, S_GC, S_SQ_INIT, S_SQ_STEP,
    S_Q1_INIT, S_Q1_DIV, S_MUL_DEN, S_DEN_SAVE, S_MUL_Q, S_Q2_INIT,
    S_Q2_DIV, S_MUL_M, S_MAG_INIT, S_MAG_DIV, S_ACC, S_EMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             axis_r;

  always_comb begin
    cmd.axis = axis_r;
    unique case (state_r)
      S_IDLE:     cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      S_SQX:      cmd.op = OP_SQX;
      S_SQY:      cmd.op = OP_SQY;
      S_RR:       cmd.op = OP_RR;
      S_SS:       cmd.op = OP_SS;
      S_GC:       cmd.op = OP_GC;
      S_SQ_INIT:  cmd.op = OP_SQ_INIT;
      S_SQ_STEP:  cmd.op = OP_SQ_STEP;
      S_Q1_INIT:  cmd.op = OP_Q1_INIT;
      S_MUL_DEN:  cmd.op = OP_MUL_DEN;
      S_DEN_SAVE: cmd.op = OP_DEN_SAVE;
      S_MUL_Q:    cmd.op = OP_MUL_Q;
      S_Q2_INIT:  cmd.op = OP_Q2_INIT;
      S_MUL_M:    cmd.op = OP_MUL_M;
      S_MAG_INIT: cmd.op = OP_MAG_INIT;
      S_ACC:      cmd.op = OP_ACC;
      S_EMIT:     cmd.op = sts.slot_free ? OP_EMIT : OP_NONE;
      S_Q1_DIV, S_Q2_DIV, S_MAG_DIV: cmd.op = OP_DIV_STEP;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign in_tready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_SQX;
        S_SQX:  state_r <= S_SQY;
        S_SQY:  state_r <= S_RR;
        S_RR:   state_r <= S_SS;
        S_SS:   state_r <= S_GC;
        S_GC: begin
          if (sts.hit)       state_r <= S_SQ_INIT;
          else if (sts.last) state_r <= S_EMIT;
          else               state_r <= S_IDLE;
        end
        S_SQ_INIT: begin
          cnt_r   <= '0;
          state_r <= S_SQ_STEP;
        end
        S_SQ_STEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_r <= S_Q1_INIT;
        end
        S_Q1_INIT: begin
          cnt_r   <= '0;
          state_r <= S_Q1_DIV;
        end
        S_Q1_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(Q_STEPS - 1)) state_r <= S_MUL_DEN;
        end
        S_MUL_DEN: state_r <= S_DEN_SAVE;
        S_DEN_SAVE: begin
          axis_r  <= 1'b0;
          state_r <= S_MUL_Q;
        end
        S_MUL_Q: state_r <= S_Q2_INIT;
        S_Q2_INIT: begin
          cnt_r   <= '0;
          state_r <= S_Q2_DIV;
        end
        S_Q2_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(Q_STEPS - 1)) state_r <= S_MUL_M;
        end
        S_MUL_M: state_r <= S_MAG_INIT;
        S_MAG_INIT: begin
          cnt_r   <= '0;
          state_r <= S_MAG_DIV;
        end
        S_MAG_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAG_STEPS - 1)) state_r <= S_ACC;
        end
        S_ACC: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_MUL_Q;
          end else if (sts.last) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: if (sts.slot_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_miss_short: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GC && !sts.hit |=> state_r == S_IDLE || state_r == S_EMIT)
    else $error("cell outside the field entered the datapath");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && sts.slot_free |=> state_r == S_IDLE)
    else $error("emit did not finish");

  a_two_axes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC && !axis_r |=> state_r == S_MUL_Q && axis_r)
    else $error("y axis skipped");

endmodule
